/* rtl/salct_pkg.sv */
// ----------------------------------------------------------------------------
// salct_pkg
// Shared types and constants of the set-associative LRU cache tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package salct_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;

   localparam int TAG_W   = 64;
   localparam int ADDR_W  = 64;
   localparam int RANK_W  = 3;
   localparam int COUNT_W = 32;
   localparam int KIND_W  = 2;

   localparam logic [RANK_W-1:0] RANK_TOP = 3'd7;

   // Access kinds.
   localparam logic [KIND_W-1:0] REQ_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] REQ_STORE  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_MODIFY = 2'd2;
   localparam logic [KIND_W-1:0] REQ_FETCH  = 2'd3;

   // Register file layout.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] CSR_IDX_SET_BITS    = 2'd0;
   localparam logic [1:0] CSR_IDX_WAYS_IN_USE = 2'd1;
   localparam logic [1:0] CSR_IDX_BLOCK_BITS  = 2'd2;

   typedef struct packed {
      logic [2:0] set_bits;
      logic [3:0] ways_in_use;
      logic [5:0] block_bits;
   } cfg_type;

   typedef struct packed {
      logic hit;
      logic miss;
      logic evict;
   } lookup_result_type;

endpackage

`default_nettype wire

/* rtl/salct_csr.sv */
// ----------------------------------------------------------------------------
// salct_csr
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module salct_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [salct_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [salct_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [salct_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready,
   output salct_pkg::cfg_type                    cfg
);

   salct_pkg::cfg_type cfg_ff;
   logic               wr_strobe;
   logic [1:0]         reg_idx;

   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_bits    <= 3'd0;
         cfg_ff.ways_in_use <= 4'd1;
         cfg_ff.block_bits  <= 6'd0;
      end else if (wr_strobe) begin
         case (reg_idx)
            salct_pkg::CSR_IDX_SET_BITS:    cfg_ff.set_bits    <= csr_pwdata[2:0];
            salct_pkg::CSR_IDX_WAYS_IN_USE: cfg_ff.ways_in_use <= csr_pwdata[3:0];
            salct_pkg::CSR_IDX_BLOCK_BITS:  cfg_ff.block_bits  <= csr_pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         salct_pkg::CSR_IDX_SET_BITS:    csr_prdata = 32'(cfg_ff.set_bits);
         salct_pkg::CSR_IDX_WAYS_IN_USE: csr_prdata = 32'(cfg_ff.ways_in_use);
         salct_pkg::CSR_IDX_BLOCK_BITS:  csr_prdata = 32'(cfg_ff.block_bits);
         default:                        csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/salct_tag_store.sv */
// ----------------------------------------------------------------------------
// salct_tag_store
// Set memory: one row per set holding valid bits, LRU ranks and tags of all
// ways, with a registered read port and a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module salct_tag_store #(
   parameter int MAX_SET_BITS = salct_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salct_pkg::DEF_MAX_WAYS
) (
   input  wire                                                clock,
   input  wire                                                reset,
   input  wire                                                rd_en,
   input  wire  [MAX_SET_BITS-1:0]                            rd_set,
   output logic [MAX_WAYS-1:0]                                rd_valid,
   output logic [MAX_WAYS-1:0][salct_pkg::RANK_W-1:0]         rd_rank,
   output logic [MAX_WAYS-1:0][salct_pkg::TAG_W-1:0]          rd_tag,
   input  wire                                                wr_en,
   input  wire  [MAX_SET_BITS-1:0]                            wr_set,
   input  wire  [MAX_WAYS-1:0]                                wr_valid,
   input  wire  [MAX_WAYS-1:0][salct_pkg::RANK_W-1:0]         wr_rank,
   input  wire  [MAX_WAYS-1:0][salct_pkg::TAG_W-1:0]          wr_tag,
   output logic                                               clear_busy
);

   localparam int DEPTH = 1 << MAX_SET_BITS;
   localparam int ROW_W = MAX_WAYS * (1 + salct_pkg::RANK_W + salct_pkg::TAG_W);

   logic [ROW_W-1:0]        row_mem_ff [DEPTH];
   logic [ROW_W-1:0]        rd_row_ff;
   logic [MAX_SET_BITS-1:0] clear_ptr_ff;
   logic                    clear_busy_ff;

   assign clear_busy = clear_busy_ff;

   // After reset every row is walked once and written with all ways invalid.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ptr_ff  <= '0;
         clear_busy_ff <= 1'b1;
      end else if (clear_busy_ff) begin
         clear_ptr_ff <= clear_ptr_ff + 1'b1;
         if (&clear_ptr_ff) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         row_mem_ff[clear_ptr_ff] <= '0;
      end else if (wr_en) begin
         row_mem_ff[wr_set] <= {wr_valid, wr_rank, wr_tag};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= row_mem_ff[rd_set];
      end
   end

   assign {rd_valid, rd_rank, rd_tag} = rd_row_ff;

endmodule

`default_nettype wire

/* rtl/salct_way_update.sv */
// ----------------------------------------------------------------------------
// salct_way_update
// Compares the tag against all ways of a set, picks the hit, free or victim
// way and computes the updated valid bits, ranks and tags of the set.
// ----------------------------------------------------------------------------
`default_nettype none

module salct_way_update #(
   parameter int MAX_WAYS  = salct_pkg::DEF_MAX_WAYS,
   parameter int WAY_CNT_W = $clog2(MAX_WAYS + 1)
) (
   input  wire  [WAY_CNT_W-1:0]                               ways,
   input  wire  [salct_pkg::TAG_W-1:0]                        tag,
   input  wire  [MAX_WAYS-1:0]                                valid,
   input  wire  [MAX_WAYS-1:0][salct_pkg::RANK_W-1:0]         rank,
   input  wire  [MAX_WAYS-1:0][salct_pkg::TAG_W-1:0]          tags,
   output salct_pkg::lookup_result_type                       result,
   output logic [MAX_WAYS-1:0]                                new_valid,
   output logic [MAX_WAYS-1:0][salct_pkg::RANK_W-1:0]         new_rank,
   output logic [MAX_WAYS-1:0][salct_pkg::TAG_W-1:0]          new_tag
);

   logic [MAX_WAYS-1:0]             in_use;
   logic [MAX_WAYS-1:0]             match;
   logic [MAX_WAYS-1:0]             free;
   logic [MAX_WAYS-1:0]             hit_oh;
   logic [MAX_WAYS-1:0]             free_oh;
   logic [MAX_WAYS-1:0]             victim_oh;
   logic [MAX_WAYS-1:0]             target_oh;
   logic [salct_pkg::RANK_W-1:0]    best_rank;
   logic [salct_pkg::RANK_W-1:0]    limit_rank;
   logic                            is_hit;
   logic                            has_free;
   logic [MAX_WAYS-1:0]             age;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = WAY_CNT_W'(w) < ways;
         match[w]  = in_use[w] && valid[w] && (tags[w] == tag);
         free[w]   = in_use[w] && !valid[w];
      end
   end

   // Lowest set bit wins.
   assign hit_oh   = match & (~match + 1'b1);
   assign free_oh  = free & (~free + 1'b1);
   assign is_hit   = |match;
   assign has_free = |free;

   // Victim is the used way of largest rank, lowest way on a tie.
   always_comb begin
      victim_oh = '0;
      best_rank = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (in_use[w] && (w == 0 || rank[w] > best_rank)) begin
            best_rank    = rank[w];
            victim_oh    = '0;
            victim_oh[w] = 1'b1;
         end
      end
   end

   assign target_oh = is_hit ? hit_oh : (has_free ? free_oh : victim_oh);

   always_comb begin
      limit_rank = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (target_oh[w]) begin
            limit_rank = limit_rank | rank[w];
         end
      end
   end

   // A fill into a free way ages every other valid line; a hit or an
   // eviction ages only lines younger than the target line.
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         age[w] = in_use[w] && valid[w] && !target_oh[w]
                  && (rank[w] != salct_pkg::RANK_TOP)
                  && ((!is_hit && has_free) || (rank[w] < limit_rank));
         if (target_oh[w]) begin
            new_rank[w] = '0;
         end else if (age[w]) begin
            new_rank[w] = rank[w] + salct_pkg::RANK_W'(1);
         end else begin
            new_rank[w] = rank[w];
         end
         new_tag[w] = (!is_hit && target_oh[w]) ? tag : tags[w];
      end
   end

   assign new_valid    = valid | target_oh;
   assign result.hit   = is_hit;
   assign result.miss  = !is_hit;
   assign result.evict = !is_hit && !has_free;

endmodule

`default_nettype wire

/* rtl/set_assoc_lru_cache_tags.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Set-associative cache tag store with true LRU replacement and running
// hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Each request (load, store, modify or instruction fetch) is accepted in
// ST_IDLE, which splits the address and reads the whole set from the set
// memory; ST_LOOKUP compares all ways in parallel, writes the updated set
// back (not for a fetch) and loads the response register. The response waits
// in its register while the next request is accepted; a lookup whose response
// register is still occupied holds until the response is taken. After reset
// the set memory is cleared one set per cycle, all 2**MAX_SET_BITS sets (64
// with the default), and no request is accepted until it is done.
// Configuration registers: set_bits at 0x0, ways_in_use at 0x4, block_bits
// at 0x8; write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_tags #(
   parameter int MAX_SET_BITS = salct_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salct_pkg::DEF_MAX_WAYS
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // Request channel
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [salct_pkg::KIND_W-1:0]         req_type,
   input  wire  [salct_pkg::ADDR_W-1:0]         req_address,
   // Response channel
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic                                 rsp_access_hit,
   output logic                                 rsp_access_miss,
   output logic                                 rsp_evicted,
   output logic [salct_pkg::COUNT_W-1:0]        rsp_hit_total,
   output logic [salct_pkg::COUNT_W-1:0]        rsp_miss_total,
   output logic [salct_pkg::COUNT_W-1:0]        rsp_eviction_total,
   // Configuration port
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [salct_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [salct_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [salct_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   localparam int WAY_CNT_W = $clog2(MAX_WAYS + 1);
   localparam logic [2:0] SB_CAP = (MAX_SET_BITS > 7) ? 3'd7 : 3'(MAX_SET_BITS);

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type                                    state_ff;
   salct_pkg::cfg_type                           cfg;

   logic [2:0]                                   sb_eff;
   logic [WAY_CNT_W-1:0]                         ways_eff;
   logic [MAX_SET_BITS-1:0]                      set_mask;
   logic [salct_pkg::ADDR_W-1:0]                 addr_shifted;
   logic [MAX_SET_BITS-1:0]                      set_sel;
   logic [6:0]                                   split;
   logic [salct_pkg::TAG_W-1:0]                  tag_sel;

   logic [salct_pkg::KIND_W-1:0]                 kind_ff;
   logic [MAX_SET_BITS-1:0]                      set_ff;
   logic [salct_pkg::TAG_W-1:0]                  tag_ff;

   logic                                         accept;
   logic                                         done;
   logic                                         wr_en;
   logic                                         clear_busy;

   logic [MAX_WAYS-1:0]                          rd_valid;
   logic [MAX_WAYS-1:0][salct_pkg::RANK_W-1:0]   rd_rank;
   logic [MAX_WAYS-1:0][salct_pkg::TAG_W-1:0]    rd_tag;
   logic [MAX_WAYS-1:0]                          new_valid;
   logic [MAX_WAYS-1:0][salct_pkg::RANK_W-1:0]   new_rank;
   logic [MAX_WAYS-1:0][salct_pkg::TAG_W-1:0]    new_tag;
   salct_pkg::lookup_result_type                 result;
   salct_pkg::lookup_result_type                 outcome;

   logic                                         rsp_valid_ff;
   logic                                         rsp_hit_ff;
   logic                                         rsp_miss_ff;
   logic                                         rsp_evict_ff;
   logic [salct_pkg::COUNT_W-1:0]                hits_ff;
   logic [salct_pkg::COUNT_W-1:0]                misses_ff;
   logic [salct_pkg::COUNT_W-1:0]                evictions_ff;
   logic [salct_pkg::COUNT_W-1:0]                hits_in;
   logic [salct_pkg::COUNT_W-1:0]                misses_in;
   logic [salct_pkg::COUNT_W-1:0]                evictions_in;
   logic [1:0]                                   hit_add;
   logic [salct_pkg::COUNT_W+1:0]                hit_sum;

   salct_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Effective configuration after clamping.
   assign sb_eff = (cfg.set_bits > SB_CAP) ? SB_CAP : cfg.set_bits;

   always_comb begin
      if (cfg.ways_in_use == 4'd0) begin
         ways_eff = WAY_CNT_W'(1);
      end else if (int'(cfg.ways_in_use) > MAX_WAYS) begin
         ways_eff = WAY_CNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WAY_CNT_W'(cfg.ways_in_use);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_SET_BITS; i++) begin
         set_mask[i] = i < int'(sb_eff);
      end
   end

   // Address split: offset, then set index, then the tag in all upper bits.
   assign addr_shifted = req_address >> cfg.block_bits;
   assign set_sel      = addr_shifted[MAX_SET_BITS-1:0] & set_mask;
   assign split        = 7'(cfg.block_bits) + 7'(sb_eff);
   assign tag_sel      = (split >= 7'd64) ? '0 : (req_address >> split);

   assign req_ready = (state_ff == ST_IDLE) && !clear_busy;
   assign accept    = req_valid && req_ready;
   assign done      = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);
   assign wr_en     = done && (kind_ff != salct_pkg::REQ_FETCH);

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_type;
         set_ff  <= set_sel;
         tag_ff  <= tag_sel;
      end
   end

   salct_tag_store #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_tag_store (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_set     (set_sel),
      .rd_valid   (rd_valid),
      .rd_rank    (rd_rank),
      .rd_tag     (rd_tag),
      .wr_en      (wr_en),
      .wr_set     (set_ff),
      .wr_valid   (new_valid),
      .wr_rank    (new_rank),
      .wr_tag     (new_tag),
      .clear_busy (clear_busy)
   );

   salct_way_update #(
      .MAX_WAYS  (MAX_WAYS),
      .WAY_CNT_W (WAY_CNT_W)
   ) u_way_update (
      .ways      (ways_eff),
      .tag       (tag_ff),
      .valid     (rd_valid),
      .rank      (rd_rank),
      .tags      (rd_tag),
      .result    (result),
      .new_valid (new_valid),
      .new_rank  (new_rank),
      .new_tag   (new_tag)
   );

   // An instruction fetch reports nothing and leaves the totals alone.
   assign outcome = (kind_ff == salct_pkg::REQ_FETCH) ? '0 : result;

   // A modify counts one extra hit, so the hit total can rise by two.
   assign hit_add = 2'(outcome.hit) + 2'(kind_ff == salct_pkg::REQ_MODIFY);
   assign hit_sum = {2'b00, hits_ff} + (salct_pkg::COUNT_W + 2)'(hit_add);
   assign hits_in = (hit_sum[salct_pkg::COUNT_W+1:salct_pkg::COUNT_W] != 2'b00)
                    ? '1 : hit_sum[salct_pkg::COUNT_W-1:0];
   assign misses_in = (outcome.miss && !(&misses_ff)) ? misses_ff + 1'b1 : misses_ff;
   assign evictions_in = (outcome.evict && !(&evictions_ff))
                         ? evictions_ff + 1'b1 : evictions_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evictions_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
            rsp_hit_ff   <= outcome.hit;
            rsp_miss_ff  <= outcome.miss;
            rsp_evict_ff <= outcome.evict;
            hits_ff      <= hits_in;
            misses_ff    <= misses_in;
            evictions_ff <= evictions_in;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_access_hit     = rsp_hit_ff;
   assign rsp_access_miss    = rsp_miss_ff;
   assign rsp_evicted        = rsp_evict_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = misses_ff;
   assign rsp_eviction_total = evictions_ff;

`ifndef ASSERT_OFF
   a_rsp_consistent : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_miss_ff) && (!rsp_evict_ff || rsp_miss_ff))
      else $error("response reports an inconsistent hit, miss and eviction");

   a_accept_to_lookup : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_LOOKUP))
      else $error("accepted transaction did not start a lookup");

   a_no_accept_clearing : assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_ready)
      else $error("request accepted while the set memory is being cleared");

   a_write_in_lookup : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_LOOKUP) && !clear_busy)
      else $error("set memory written outside a lookup");

   a_totals_monotonic : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (hits_ff >= $past(hits_ff)) && (misses_ff >= $past(misses_ff))
               && (evictions_ff >= $past(evictions_ff)))
      else $error("running total decreased");
`endif

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache tag store.
// A behavioral copy of the tag store predicts hit, miss, eviction and the
// running totals of each access. Directed accesses come first, then random
// traffic under several cache geometries and three idling modes. The
// registers are reprogrammed only while no transaction is in flight.
// ----------------------------------------------------------------------------

module tb;

   localparam int CLK_PERIOD     = 10;
   localparam int LINES          = (1 << salct_pkg::DEF_MAX_SET_BITS)
                                   * salct_pkg::DEF_MAX_WAYS;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 102;
   localparam int POOL_SIZE      = 12;
   localparam logic [1:0] CSR_IDX_UNUSED = 2'd3;

   typedef struct packed {
      salct_pkg::lookup_result_type       flags;
      logic [salct_pkg::COUNT_W-1:0]      hits;
      logic [salct_pkg::COUNT_W-1:0]      misses;
      logic [salct_pkg::COUNT_W-1:0]      evictions;
   } access_outcome_type;

   logic                             clock       = 1'b0;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_ready;
   logic [salct_pkg::KIND_W-1:0]     req_type    = salct_pkg::REQ_LOAD;
   logic [salct_pkg::ADDR_W-1:0]     req_address = '0;
   logic                             rsp_valid;
   logic                             rsp_ready   = 1'b0;
   logic                             rsp_access_hit;
   logic                             rsp_access_miss;
   logic                             rsp_evicted;
   logic [salct_pkg::COUNT_W-1:0]    rsp_hit_total;
   logic [salct_pkg::COUNT_W-1:0]    rsp_miss_total;
   logic [salct_pkg::COUNT_W-1:0]    rsp_eviction_total;
   logic                             csr_psel    = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite  = 1'b0;
   logic [salct_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [salct_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [salct_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   set_assoc_lru_cache_tags u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_access_hit     (rsp_access_hit),
      .rsp_access_miss    (rsp_access_miss),
      .rsp_evicted        (rsp_evicted),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Behavioral tag store: same geometry as the block's defaults.
   logic                            way_valid [LINES];
   logic [salct_pkg::TAG_W-1:0]     way_tag   [LINES];
   logic [salct_pkg::RANK_W-1:0]    way_rank  [LINES];
   logic [salct_pkg::COUNT_W-1:0]   pred_hits;
   logic [salct_pkg::COUNT_W-1:0]   pred_misses;
   logic [salct_pkg::COUNT_W-1:0]   pred_evictions;
   salct_pkg::cfg_type              cache_cfg;

   access_outcome_type              pending_outcomes [$];
   logic [salct_pkg::TAG_W-1:0]     tag_pool [POOL_SIZE];

   int send_idle_pct   = 30;
   int recv_stall_pct  = 61;
   int mismatch_count  = 0;
   int checked_count   = 0;
   int accepted_count  = 0;
   int settings_used   = 0;
   int quiet_cycles    = 0;

   function automatic logic [salct_pkg::COUNT_W-1:0] sat_inc(
         input logic [salct_pkg::COUNT_W-1:0] x);
      return (x == '1) ? x : x + 1'b1;
   endfunction

   function automatic int eff_set_bits();
      return (cache_cfg.set_bits > salct_pkg::DEF_MAX_SET_BITS)
             ? salct_pkg::DEF_MAX_SET_BITS : int'(cache_cfg.set_bits);
   endfunction

   function automatic int eff_ways();
      if (cache_cfg.ways_in_use == 0)
         return 1;
      return (cache_cfg.ways_in_use > salct_pkg::DEF_MAX_WAYS)
             ? salct_pkg::DEF_MAX_WAYS : int'(cache_cfg.ways_in_use);
   endfunction

   // Every valid used way other than skip whose rank is below limit gets
   // one step older, saturating at the top rank.
   function automatic void age_ranks(input int base, input int nways, input int limit,
                                     input int skip);
      for (int w = 0; w < nways; w++) begin
         if (w != skip && way_valid[base + w] && way_rank[base + w] < limit &&
             way_rank[base + w] < salct_pkg::RANK_TOP)
            way_rank[base + w] = way_rank[base + w] + 1'b1;
      end
   endfunction

   function automatic access_outcome_type predict_access(
         input logic [salct_pkg::KIND_W-1:0] kind,
         input logic [salct_pkg::ADDR_W-1:0] addr);
      access_outcome_type o;
      int sb, nways, base, target, split;
      logic [63:0] set_idx, tag_v;
      o = '0;
      if (kind != salct_pkg::REQ_FETCH) begin
         sb      = eff_set_bits();
         nways   = eff_ways();
         set_idx = (addr >> cache_cfg.block_bits) & ((64'd1 << sb) - 64'd1);
         split   = int'(cache_cfg.block_bits) + sb;
         tag_v   = (split >= 64) ? 64'd0 : addr >> split;
         base    = int'(set_idx) * salct_pkg::DEF_MAX_WAYS;
         target  = nways;
         // Walk downward so that the lowest matching way wins.
         for (int w = nways - 1; w >= 0; w--)
            if (way_valid[base + w] && way_tag[base + w] == tag_v)
               target = w;
         if (target < nways) begin
            o.flags.hit = 1'b1;
            age_ranks(base, nways, way_rank[base + target], target);
            pred_hits = sat_inc(pred_hits);
         end else begin
            o.flags.miss = 1'b1;
            for (int w = nways - 1; w >= 0; w--)
               if (!way_valid[base + w])
                  target = w;
            if (target < nways) begin
               age_ranks(base, nways, int'(salct_pkg::RANK_TOP) + 1, target);
            end else begin
               target = 0;
               for (int w = 1; w < nways; w++)
                  if (way_rank[base + w] > way_rank[base + target])
                     target = w;
               o.flags.evict = 1'b1;
               age_ranks(base, nways, way_rank[base + target], target);
               pred_evictions = sat_inc(pred_evictions);
            end
            pred_misses = sat_inc(pred_misses);
            way_valid[base + target] = 1'b1;
            way_tag[base + target]   = tag_v;
         end
         way_rank[base + target] = '0;
         if (kind == salct_pkg::REQ_MODIFY)
            pred_hits = sat_inc(pred_hits);
      end
      o.hits      = pred_hits;
      o.misses    = pred_misses;
      o.evictions = pred_evictions;
      return o;
   endfunction

   // Builds an address from its parts under the current split.
   function automatic logic [salct_pkg::ADDR_W-1:0] compose_address(
         input logic [63:0] tag_v,
         input logic [63:0] set_v,
         input logic [63:0] offset);
      logic [salct_pkg::ADDR_W-1:0] a;
      int sb, split;
      sb    = eff_set_bits();
      split = int'(cache_cfg.block_bits) + sb;
      a = (offset & ((64'd1 << cache_cfg.block_bits) - 64'd1)) |
          ((set_v & ((64'd1 << sb) - 64'd1)) << cache_cfg.block_bits);
      if (split < 64)
         a = a | (tag_v << split);
      return a;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("Mismatch on %s at %0t: got %h, expected %h (response %0d)",
                  what, $realtime, got, want, checked_count);
   endtask

   // Sends one access; called at a falling edge and returns at one.
   task automatic send_access(input logic [salct_pkg::KIND_W-1:0] kind,
                              input logic [salct_pkg::ADDR_W-1:0] addr);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_address <= addr;
      do @(posedge clock); while (!req_ready);
      pending_outcomes.push_back(predict_access(kind, addr));
      accepted_count++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx,
                            input logic [salct_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= salct_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         salct_pkg::CSR_IDX_SET_BITS:    cache_cfg.set_bits    = value[2:0];
         salct_pkg::CSR_IDX_WAYS_IN_USE: cache_cfg.ways_in_use = value[3:0];
         salct_pkg::CSR_IDX_BLOCK_BITS:  cache_cfg.block_bits  = value[5:0];
         default: ;
      endcase
   endtask

   task automatic csr_read_check(input logic [1:0] idx,
                                 input logic [salct_pkg::CSR_DATA_W-1:0] want);
      logic [salct_pkg::CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= salct_pkg::CSR_ADDR_W'({idx, 2'b00});
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want)
         report_mismatch($sformatf("register %0d readback", idx), got, want);
   endtask

   task automatic check_registers();
      csr_read_check(salct_pkg::CSR_IDX_SET_BITS,
                     salct_pkg::CSR_DATA_W'(cache_cfg.set_bits));
      csr_read_check(salct_pkg::CSR_IDX_WAYS_IN_USE,
                     salct_pkg::CSR_DATA_W'(cache_cfg.ways_in_use));
      csr_read_check(salct_pkg::CSR_IDX_BLOCK_BITS,
                     salct_pkg::CSR_DATA_W'(cache_cfg.block_bits));
   endtask

   // The upper bits of each write carry junk that the register must drop.
   task automatic set_cache_config(input logic [2:0] sb, input logic [3:0] nw,
                                   input logic [5:0] bb);
      wait_drained();
      csr_write(salct_pkg::CSR_IDX_SET_BITS,
                ($urandom & ~32'h7) | salct_pkg::CSR_DATA_W'(sb));
      csr_write(salct_pkg::CSR_IDX_WAYS_IN_USE,
                ($urandom & ~32'hF) | salct_pkg::CSR_DATA_W'(nw));
      csr_write(salct_pkg::CSR_IDX_BLOCK_BITS,
                ($urandom & ~32'h3F) | salct_pkg::CSR_DATA_W'(bb));
      check_registers();
      settings_used++;
   endtask

   task automatic test_register_access();
      check_registers();
      csr_write(CSR_IDX_UNUSED, $urandom);
      check_registers();
   endtask

   task automatic test_directed_accesses();
      // Single-way default geometry: fill, hit, modify, eviction, fetch.
      send_access(salct_pkg::REQ_LOAD, 64'd0);
      send_access(salct_pkg::REQ_LOAD, 64'd0);
      send_access(salct_pkg::REQ_MODIFY, 64'd0);
      send_access(salct_pkg::REQ_STORE, '1);
      send_access(salct_pkg::REQ_FETCH, '1);
      // Four ways: fill a set, refresh one line, then two LRU replacements.
      set_cache_config(3'd2, 4'd4, 6'd4);
      for (int t = 1; t <= 4; t++)
         send_access(salct_pkg::REQ_LOAD, compose_address(64'(t), 64'd1, 64'(t)));
      send_access(salct_pkg::REQ_LOAD, compose_address(64'd1, 64'd1, 64'd0));
      send_access(salct_pkg::REQ_STORE, compose_address(64'd5, 64'd1, 64'd15));
      send_access(salct_pkg::REQ_MODIFY, compose_address(64'd2, 64'd1, 64'd0));
      send_access(salct_pkg::REQ_LOAD, compose_address(64'd4, 64'd2, 64'd0));
      // Too many set bits, zero ways, offset plus set bits at 64: tag is 0.
      set_cache_config(3'd7, 4'd0, 6'd58);
      send_access(salct_pkg::REQ_LOAD, '1);
      send_access(salct_pkg::REQ_LOAD, 64'hFC00_0000_0000_0000);
      send_access(salct_pkg::REQ_STORE, 64'd0);
      // Ways above the maximum and the widest offset.
      set_cache_config(3'd6, 4'd15, 6'd63);
      send_access(salct_pkg::REQ_STORE, 64'd0);
      send_access(salct_pkg::REQ_STORE, 64'h8000_0000_0000_0000);
      send_access(salct_pkg::REQ_MODIFY, 64'h8000_0000_0000_0001);
   endtask

   task automatic run_random_phase(input int n_items);
      int real_items, sb, nw, r;
      bit paused;
      logic [salct_pkg::KIND_W-1:0] kind;
      logic [salct_pkg::ADDR_W-1:0] addr;
      logic [63:0] set_v;
      real_items = 0;
      paused     = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++)
         tag_pool[i] = (i < 6) ? 64'(i) : {$urandom, $urandom};
      while (real_items < n_items) begin
         sb = eff_set_bits();
         nw = eff_ways();
         r  = $urandom_range(0, 99);
         kind = (r < 35) ? salct_pkg::REQ_LOAD :
                (r < 60) ? salct_pkg::REQ_STORE :
                (r < 85) ? salct_pkg::REQ_MODIFY : salct_pkg::REQ_FETCH;
         if ($urandom_range(0, 99) < 15) begin
            addr = {$urandom, $urandom};
         end else begin
            // Crowd a few sets with a small pool of tags to force reuse.
            set_v = ($urandom_range(0, 99) < 60)
                    ? 64'($urandom_range(0, 1))
                    : 64'($urandom_range(0, (1 << sb) - 1));
            addr = compose_address(tag_pool[$urandom_range(0, nw + 2)], set_v,
                                   {$urandom, $urandom});
         end
         send_access(kind, addr);
         if (kind != salct_pkg::REQ_FETCH)
            real_items++;
         if (!paused && real_items == n_items / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
   endtask

   task automatic test_random_traffic();
      int send_pcts [3] = '{30, 61, 0};
      int recv_pcts [3] = '{61, 30, 0};
      salct_pkg::cfg_type geometries [9] = '{
         '{3'd2, 4'd4, 6'd4},  '{3'd0, 4'd8, 6'd0},  '{3'd7, 4'd9, 6'd6},
         '{3'd3, 4'd2, 6'd10}, '{3'd6, 4'd8, 6'd58}, '{3'd1, 4'd0, 6'd63},
         '{3'd4, 4'd8, 6'd2},  '{3'd5, 4'd3, 6'd30}, '{3'd6, 4'd8, 6'd0}
      };
      for (int mode = 0; mode < 3; mode++) begin
         for (int g = 0; g < 3; g++) begin
            set_cache_config(geometries[3 * mode + g].set_bits,
                             geometries[3 * mode + g].ways_in_use,
                             geometries[3 * mode + g].block_bits);
            send_idle_pct  = send_pcts[mode];
            recv_stall_pct = recv_pcts[mode];
            run_random_phase(PHASE_ITEMS);
         end
      end
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   always @(posedge clock) begin
      access_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected response", 64'd0, 64'd0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_access_hit !== want.flags.hit)
               report_mismatch("access_hit", rsp_access_hit, want.flags.hit);
            if (rsp_access_miss !== want.flags.miss)
               report_mismatch("access_miss", rsp_access_miss, want.flags.miss);
            if (rsp_evicted !== want.flags.evict)
               report_mismatch("evicted", rsp_evicted, want.flags.evict);
            if (rsp_hit_total !== want.hits)
               report_mismatch("hit_total", rsp_hit_total, want.hits);
            if (rsp_miss_total !== want.misses)
               report_mismatch("miss_total", rsp_miss_total, want.misses);
            if (rsp_eviction_total !== want.evictions)
               report_mismatch("eviction_total", rsp_eviction_total, want.evictions);
         end
         checked_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d responses outstanding",
                  quiet_cycles, pending_outcomes.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < LINES; i++) begin
         way_valid[i] = 1'b0;
         way_tag[i]   = '0;
         way_rank[i]  = '0;
      end
      pred_hits      = '0;
      pred_misses    = '0;
      pred_evictions = '0;
      cache_cfg      = '{set_bits: 3'd0, ways_in_use: 4'd1, block_bits: 6'd0};

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_access();
      test_directed_accesses();
      test_random_traffic();

      wait_drained();
      repeat (8) @(negedge clock);
      $display("Run covered %0d accesses over %0d cache geometries plus reset defaults.",
               accepted_count, settings_used);
      $display("Predicted totals: %0d hits, %0d misses, %0d evictions; %0d mismatches.",
               pred_hits, pred_misses, pred_evictions, mismatch_count);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
